FILE: sv/sfs_pkg.sv
// Shared constants, codes and types of the sprite frame sequencer.
package sfs_pkg;

  // Fixed field widths.
  localparam int ACC_W      = 32;
  localparam int ELAPSED_W  = 16;
  localparam int LOOP_W     = 16;
  localparam int DELAY_W    = 10;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;

  // Defaults of the top-level parameters.
  localparam int MAX_FRAMES_DEF    = 64;
  localparam int FRAME_ID_BITS_DEF = 16;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_DELAY = 2'd0,
    CFG_FRAME_COUNT = 2'd1,
    CFG_LOOP_ENABLE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_DIV_N,
    S_ADV,
    S_DIV_LOOP,
    S_LOOPS,
    S_READ,
    S_RESP
  } state_t;

  // Frame table port controls.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: sv/sfs_frame_mem.sv
// Frame table: one write port, one registered read port.
module sfs_frame_mem import sfs_pkg::*; #(
  parameter int DEPTH  = MAX_FRAMES_DEF,
  parameter int ADDR_W = 6,
  parameter int DATA_W = FRAME_ID_BITS_DEF
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port: the data comes out in the cycle after the read enable.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/sfs_div.sv
// Restoring divider that produces one quotient bit per cycle.
module sfs_div import sfs_pkg::*; #(
  parameter int DVD_W = ACC_W,
  parameter int DVS_W = DELAY_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {remainder, quotient[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  // Control: step count and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient fills in as the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!diff[DVS_W]) begin
        remainder <= diff[DVS_W-1:0];
        quotient  <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        remainder <= trial[DVS_W-1:0];
        quotient  <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/sprite_frame_sequencer_core.sv
// Sprite frame sequencer top level: control, timing state and result register.
//
// The block takes one request at a time and answers each with one result. A load,
// restart, no-op or rejected tick passes from acceptance through the read state and
// the response state into the result register; the frame id always comes out of the
// frame table's registered read port. The advance count is (accumulator - 1)
// divided by the frame delay. When a looping animation passes its end, the wrap
// position is the leftover count modulo the frame count. Both are worked out on
// one shared divider that yields one bit per cycle. A tick with zero delay or an
// empty accumulator skips the first division, and a tick that stays short of the
// end or does not loop skips the second. A new request is taken as soon as the
// previous result is in the output register, even while that result still waits
// to be taken.
module sprite_frame_sequencer_core import sfs_pkg::*; #(
  parameter  int MAX_FRAMES    = MAX_FRAMES_DEF,
  parameter  int FRAME_ID_BITS = FRAME_ID_BITS_DEF,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int CNT_W = $clog2(MAX_FRAMES + 1),
  localparam int CFG_W = (CNT_W > DELAY_W) ? CNT_W : DELAY_W
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // Request channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [ELAPSED_W-1:0]     elapsed_ms,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic [FRAME_ID_BITS-1:0] entry_frame,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     status,
  output logic [FRAME_ID_BITS-1:0] frame_id,
  output logic [IDX_W-1:0]         current_index,
  output logic                     frame_changed,
  output logic                     looped_now,
  output logic [LOOP_W-1:0]        loops_done,
  output logic                     finished
);

  // Configuration registers.
  logic [DELAY_W-1:0] frame_delay_ms;
  logic [CNT_W-1:0]   frame_count;
  logic               loop_enable;

  // Timing state.
  logic [ACC_W-1:0]  acc;
  logic [IDX_W-1:0]  position;
  logic [LOOP_W-1:0] loop_counter;
  logic              changed_flag;
  logic              looped_flag;

  // Per-request working registers.
  state_t            state;
  state_t            state_next;
  logic              status_r;
  logic [ACC_W-1:0]  n_adv;
  logic [ACC_W-1:0]  loop_add;

  // Handshake and shared units.
  logic              accept;
  logic              out_load;
  logic              div_start;
  logic [ACC_W-1:0]  div_dividend;
  logic [CFG_W-1:0]  div_divisor;
  logic              div_done;
  logic [ACC_W-1:0]  div_quo;
  logic [CFG_W-1:0]  div_rem;
  mem_ctl_t          mem_ctl;
  logic [FRAME_ID_BITS-1:0] mem_rdata;

  // Datapath helpers.
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_sat;
  logic              reject;
  logic              load_ok;
  logic [CNT_W-1:0]  eff_count;
  logic [CNT_W:0]    pos_ext;
  logic [CNT_W-1:0]  step_to_end;
  logic [ACC_W:0]    adv_diff;
  logic [CNT_W-1:0]  last_pos;
  logic [IDX_W-1:0]  hold_pos;
  logic [ACC_W:0]    loop_sum;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_RESP) && (!out_valid || !out_stall);

  // Saturating accumulator update and request checks.
  always_comb begin
    acc_sum = {1'b0, acc} + (ACC_W+1)'(elapsed_ms);
    acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    reject  = !loop_enable && (loop_counter != '0);
    load_ok = {1'b0, entry_index} < (IDX_W+1)'(MAX_FRAMES);
  end

  // Effective frame count, steps to the end, and the leftover advance count.
  always_comb begin
    if (frame_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (frame_count > CNT_W'(MAX_FRAMES)) begin
      eff_count = CNT_W'(MAX_FRAMES);
    end else begin
      eff_count = frame_count;
    end
    pos_ext = (CNT_W+1)'(position);
    if (pos_ext + (CNT_W+1)'(1) >= {1'b0, eff_count}) begin
      step_to_end = CNT_W'(1);
    end else begin
      step_to_end = eff_count - CNT_W'(position);
    end
    adv_diff = {1'b0, n_adv} - (ACC_W+1)'(step_to_end);
    last_pos = eff_count - CNT_W'(1);
    if (pos_ext >= {1'b0, last_pos}) begin
      hold_pos = position;
    end else begin
      hold_pos = last_pos[IDX_W-1:0];
    end
    loop_sum = (ACC_W+1)'(loop_counter) + {1'b0, loop_add} + (ACC_W+1)'(1);
  end

  // Next state and unit controls.
  always_comb begin
    state_next    = state;
    div_start     = 1'b0;
    div_dividend  = acc - ACC_W'(1);
    div_divisor   = CFG_W'(frame_delay_ms);
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(cmd))
            CMD_TICK: state_next = reject ? S_READ : S_TICK;
            CMD_LOAD: begin
              mem_ctl.wr_en = load_ok;
              state_next    = S_READ;
            end
            default: state_next = S_READ;
          endcase
        end
      end
      S_TICK: begin
        if (frame_delay_ms == '0) begin
          state_next = S_ADV;
        end else if (acc == '0) begin
          state_next = S_READ;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV_N;
        end
      end
      S_DIV_N: begin
        if (div_done) begin
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        if (n_adv == '0 || adv_diff[ACC_W]) begin
          state_next = S_READ;
        end else if (loop_enable) begin
          div_start    = 1'b1;
          div_dividend = adv_diff[ACC_W-1:0];
          div_divisor  = CFG_W'(eff_count);
          state_next   = S_DIV_LOOP;
        end else begin
          state_next = S_LOOPS;
        end
      end
      S_DIV_LOOP: begin
        if (div_done) begin
          state_next = S_LOOPS;
        end
      end
      S_LOOPS: state_next = S_READ;
      S_READ: begin
        mem_ctl.rd_en = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_delay_ms <= '0;
      frame_count    <= CNT_W'(1);
      loop_enable    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_DELAY: frame_delay_ms <= cfg_data[DELAY_W-1:0];
        CFG_FRAME_COUNT: frame_count    <= cfg_data[CNT_W-1:0];
        CFG_LOOP_ENABLE: loop_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Timing state: read, modify and write back per step of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      position     <= '0;
      loop_counter <= '0;
      changed_flag <= 1'b0;
      looped_flag  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd_t'(cmd) == CMD_TICK && !reject) begin
              acc          <= acc_sat;
              changed_flag <= 1'b0;
              looped_flag  <= 1'b0;
            end else if (cmd_t'(cmd) == CMD_RESTART) begin
              acc          <= '0;
              position     <= '0;
              loop_counter <= '0;
              changed_flag <= 1'b0;
              looped_flag  <= 1'b0;
            end
          end
        end
        S_DIV_N: begin
          if (div_done) begin
            acc <= ACC_W'(div_rem) + ACC_W'(1);
          end
        end
        S_ADV: begin
          if (n_adv != '0) begin
            changed_flag <= 1'b1;
            if (adv_diff[ACC_W]) begin
              position <= position + n_adv[IDX_W-1:0];
            end else begin
              looped_flag <= 1'b1;
              if (!loop_enable) begin
                position <= hold_pos;
              end
            end
          end
        end
        S_DIV_LOOP: begin
          if (div_done) begin
            position <= div_rem[IDX_W-1:0];
          end
        end
        S_LOOPS: begin
          if (loop_sum > (ACC_W+1)'({LOOP_W{1'b1}})) begin
            loop_counter <= '1;
          end else begin
            loop_counter <= loop_sum[LOOP_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          status_r <= (cmd_t'(cmd) == CMD_TICK) && reject;
        end
      end
      S_TICK: n_adv <= {{(ACC_W-1){1'b0}}, acc != '0};
      S_DIV_N: begin
        if (div_done) begin
          n_adv <= div_quo;
        end
      end
      S_ADV: loop_add <= adv_diff[ACC_W-1:0];
      S_DIV_LOOP: begin
        if (div_done) begin
          loop_add <= div_quo;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= status_r;
      frame_id      <= mem_rdata;
      current_index <= position;
      frame_changed <= changed_flag;
      looped_now    <= looped_flag;
      loops_done    <= loop_counter;
      finished      <= !loop_enable && (loop_counter != '0);
    end
  end

  // Shared divider for the advance count and the wrap position.
  sfs_div #(
    .DVD_W (ACC_W),
    .DVS_W (CFG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Frame table.
  sfs_frame_mem #(
    .DEPTH  (MAX_FRAMES),
    .ADDR_W (IDX_W),
    .DATA_W (FRAME_ID_BITS)
  ) u_frame_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (entry_index),
    .wr_data (entry_frame),
    .rd_addr (position),
    .rd_data (mem_rdata)
  );

endmodule

FILE: sv/sfs_checker.sv
// Port-level checks of the sprite frame sequencer, bound to the top level.
module sfs_checker import sfs_pkg::*; #(
  parameter int FRAME_ID_BITS = FRAME_ID_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     status,
  input logic [FRAME_ID_BITS-1:0] frame_id,
  input logic                     frame_changed,
  input logic                     looped_now,
  input logic [LOOP_W-1:0]        loops_done,
  input logic                     finished
);

  // One request at a time: the channel closes right after a request is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while the previous one is still at work");

  // A waiting result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_id) && $stable(loops_done))
    else $error("stalled result changed or dropped");

  // A rejected tick only happens on a finished animation.
  a_reject_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> finished)
    else $error("rejected tick without a finished animation");

  // Passing the end always counts as a frame change.
  a_loop_changed: assert property (@(posedge clk) disable iff (rst)
    out_valid && looped_now |-> frame_changed)
    else $error("looped without a frame change");

  // Finished means the end was passed at least once.
  a_finished_loops: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> loops_done != '0)
    else $error("finished with a zero loop count");

endmodule

bind sprite_frame_sequencer_core sfs_checker #(
  .FRAME_ID_BITS (FRAME_ID_BITS)
) u_sfs_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for the sprite frame sequencer core.
module testbench;
  import sfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_BITS   = $clog2(MAX_FRAMES_DEF);
  localparam int ID_BITS    = FRAME_ID_BITS_DEF;
  // The frame delay is the widest register.
  localparam int CFG_DATA_W = DELAY_W;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int PHASES          = 12;

  typedef struct packed {
    logic               status;
    logic [ID_BITS-1:0] frame_id;
    logic [IDX_BITS-1:0] index;
    logic               changed;
    logic               looped;
    logic [LOOP_W-1:0]  loops;
    logic               fin;
  } seq_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd;
  logic [ELAPSED_W-1:0]  elapsed_ms;
  logic [IDX_BITS-1:0]   entry_index;
  logic [ID_BITS-1:0]    entry_frame;
  logic                  out_valid;
  logic                  out_stall;
  logic                  status;
  logic [ID_BITS-1:0]    frame_id;
  logic [IDX_BITS-1:0]   current_index;
  logic                  frame_changed;
  logic                  looped_now;
  logic [LOOP_W-1:0]     loops_done;
  logic                  finished;

  // Shadow copy of the sequencer: registers, timing state and frame table.
  bit [DELAY_W-1:0]  seq_delay;
  bit [6:0]          seq_count;
  bit                seq_loop_en;
  bit [ACC_W-1:0]    seq_acc;
  bit [IDX_BITS-1:0] seq_pos;
  bit [LOOP_W-1:0]   seq_loops;
  bit                seq_changed;
  bit                seq_looped;
  bit [ID_BITS-1:0]  sprite_table [MAX_FRAMES_DEF];

  seq_result_t expected_results [$];
  int          mismatches;
  bit          idle_on;
  int          stall_left;

  sprite_frame_sequencer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .elapsed_ms   (elapsed_ms),
    .entry_index  (entry_index),
    .entry_frame  (entry_frame),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .frame_id     (frame_id),
    .current_index(current_index),
    .frame_changed(frame_changed),
    .looped_now   (looped_now),
    .loops_done   (loops_done),
    .finished     (finished)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Computes the result of one request and updates the shadow state.
  function automatic seq_result_t step_sequencer(cmd_t c, bit [ELAPSED_W-1:0] ms,
                                                 bit [IDX_BITS-1:0] idx,
                                                 bit [ID_BITS-1:0] fr);
    longint unsigned a, n, ne, s1, rest, lp;
    seq_result_t r;
    r.status = 1'b0;
    case (c)
      CMD_TICK: begin
        if (!seq_loop_en && seq_loops != 0) begin
          r.status = 1'b1;
        end else begin
          a = seq_acc;
          a = a + ms;
          if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
          seq_changed = 1'b0;
          seq_looped  = 1'b0;
          // A zero delay allows one advance and keeps the accumulator.
          if (seq_delay == 0) begin
            n = (a > 0) ? 1 : 0;
          end else begin
            n = (a == 0) ? 0 : (a - 1) / seq_delay;
            a = a - n * seq_delay;
          end
          seq_acc = a[ACC_W-1:0];
          if (n != 0) begin
            ne = (seq_count == 0) ? 1 : (seq_count > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF
                                                                    : seq_count;
            seq_changed = 1'b1;
            s1 = (seq_pos + 1 >= ne) ? 1 : ne - seq_pos;
            if (n < s1) begin
              seq_pos = IDX_BITS'(seq_pos + n);
            end else begin
              // Passing the end: wrap when looping, otherwise hold.
              seq_looped = 1'b1;
              rest = n - s1;
              if (seq_loop_en) begin
                lp = 1 + rest / ne;
                seq_pos = IDX_BITS'(rest % ne);
              end else begin
                lp = rest + 1;
                if (seq_pos < ne - 1) seq_pos = IDX_BITS'(ne - 1);
              end
              lp = lp + seq_loops;
              seq_loops = (lp > 65535) ? 16'hFFFF : lp[LOOP_W-1:0];
            end
          end
        end
      end
      CMD_RESTART: begin
        seq_acc     = '0;
        seq_pos     = '0;
        seq_loops   = '0;
        seq_changed = 1'b0;
        seq_looped  = 1'b0;
      end
      CMD_LOAD: begin
        sprite_table[idx] = fr;
      end
      default: begin
      end
    endcase
    r.frame_id = sprite_table[seq_pos];
    r.index    = seq_pos;
    r.changed  = seq_changed;
    r.looped   = seq_looped;
    r.loops    = seq_loops;
    r.fin      = !seq_loop_en && seq_loops != 0;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
    $display("%0t: mismatch in %s: expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Sends one request and records its expected result once it is taken.
  task automatic send_request(cmd_t c, bit [ELAPSED_W-1:0] ms, bit [IDX_BITS-1:0] idx,
                              bit [ID_BITS-1:0] fr);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd         = c;
    elapsed_ms  = ms;
    entry_index = idx;
    entry_frame = fr;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_results.push_back(step_sequencer(c, ms, idx, fr));
  endtask

  // Drops the request valid and waits until every result has been taken.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t which, bit [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = which;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (which)
      CFG_FRAME_DELAY: seq_delay   = value[DELAY_W-1:0];
      CFG_FRAME_COUNT: seq_count   = value[6:0];
      CFG_LOOP_ENABLE: seq_loop_en = value[0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(int delay, int count, int loop_en);
    wait_idle();
    write_register(CFG_FRAME_DELAY, CFG_DATA_W'(delay));
    write_register(CFG_FRAME_COUNT, CFG_DATA_W'(count));
    write_register(CFG_LOOP_ENABLE, CFG_DATA_W'(loop_en));
  endtask

  // Receiver: a random stall ahead of each result, or none in quiet phases.
  always @(negedge clk) begin
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // Compare every taken result with the oldest expectation.
  always @(posedge clk) begin : result_check
    seq_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      stall_left <= idle_on ? $urandom_range(0, 8) : 0;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) report_mismatch("status", want.status, status);
        if (frame_id !== want.frame_id) report_mismatch("frame_id", want.frame_id, frame_id);
        if (current_index !== want.index)
          report_mismatch("current_index", want.index, current_index);
        if (frame_changed !== want.changed)
          report_mismatch("frame_changed", want.changed, frame_changed);
        if (looped_now !== want.looped) report_mismatch("looped_now", want.looped, looped_now);
        if (loops_done !== want.loops) report_mismatch("loops_done", want.loops, loops_done);
        if (finished !== want.fin) report_mismatch("finished", want.fin, finished);
      end
    end
  end

  // Every table entry is written first, so no read ever hits an empty entry.
  task automatic test_fill_table();
    send_request(CMD_LOAD, ELAPSED_W'($urandom), 0, 16'hFFFF);
    send_request(CMD_LOAD, ELAPSED_W'($urandom), 1, 16'h0000);
    for (int i = 2; i < MAX_FRAMES_DEF; i++) begin
      send_request(CMD_LOAD, ELAPSED_W'($urandom), IDX_BITS'(i), ID_BITS'($urandom));
    end
  endtask

  // Strict comparison against the delay, multi-frame steps and wrapping.
  task automatic test_tick_timing();
    set_config(100, 4, 1);
    send_request(CMD_TICK, 0, 0, 0);
    send_request(CMD_TICK, 100, 0, 0);
    send_request(CMD_TICK, 1, 0, 0);
    send_request(CMD_TICK, 350, 0, 0);
    send_request(CMD_TICK, 16'hFFFF, 6'h3F, 16'hFFFF);
    send_request(CMD_NOP, 0, 0, 0);
    send_request(CMD_RESTART, 0, 0, 0);
  endtask

  // A non-looping animation finishes, rejects ticks, and resumes when looping.
  task automatic test_end_of_animation();
    set_config(250, 3, 0);
    send_request(CMD_TICK, 600, 0, 0);
    send_request(CMD_TICK, 151, 0, 0);
    send_request(CMD_TICK, 10, 0, 0);
    send_request(CMD_RESTART, 0, 0, 0);
    send_request(CMD_TICK, 1000, 0, 0);
    set_config(1023, 3, 1);
    send_request(CMD_TICK, 3000, 0, 0);
  endtask

  // Zero delay: one advance per tick with a nonzero accumulator, nothing subtracted.
  task automatic test_zero_delay();
    set_config(0, 2, 1);
    send_request(CMD_TICK, 0, 0, 0);
    send_request(CMD_TICK, 1, 0, 0);
    send_request(CMD_TICK, 16'hFFFF, 0, 0);
  endtask

  // Position left beyond a lowered frame count, and out-of-range counts.
  task automatic test_shrunk_count();
    set_config(1, 64, 0);
    send_request(CMD_RESTART, 0, 0, 0);
    send_request(CMD_TICK, 41, 0, 0);
    set_config(1, 5, 0);
    send_request(CMD_TICK, 2, 0, 0);
    set_config(1, 64, 1);
    send_request(CMD_RESTART, 0, 0, 0);
    send_request(CMD_TICK, 41, 0, 0);
    set_config(1, 5, 1);
    send_request(CMD_TICK, 3, 0, 0);
    set_config(1, 0, 1);
    send_request(CMD_TICK, 3, 0, 0);
    set_config(1023, 127, 1);
    send_request(CMD_TICK, 16'hFFFF, 0, 0);
  endtask

  // The loop counter saturates after two maximal ticks on a one-frame loop.
  task automatic test_saturation();
    set_config(1, 1, 1);
    send_request(CMD_RESTART, 0, 0, 0);
    send_request(CMD_TICK, 16'hFFFF, 0, 0);
    send_request(CMD_TICK, 16'hFFFF, 0, 0);
    send_request(CMD_TICK, 16'hFFFF, 0, 0);
  endtask

  // Phases of random traffic, each under its own register setting.
  task automatic test_random_traffic();
    int delay, count, loop_en, pick;
    longint unsigned span;
    bit [ELAPSED_W-1:0] ms;
    for (int ph = 0; ph < PHASES; ph++) begin
      pick = $urandom_range(0, 5);
      delay = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 1023
                                                              : $urandom_range(2, 1000);
      pick = $urandom_range(0, 7);
      count = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(65, 127) : (pick == 2) ? 64
            : (pick == 3) ? 1 : $urandom_range(1, 64);
      // Bits above the count field are ignored by the register.
      count = count | ($urandom_range(0, 7) << 7);
      loop_en = $urandom_range(0, 1);
      set_config(delay, count, loop_en);
      if (ph == PHASES / 2) write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
      idle_on = ($urandom_range(0, 3) != 0);
      span = 2 * longint'(delay) + 1;
      if (span > 65535) span = 65535;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 19);
        ms = ELAPSED_W'((pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : (pick == 2) ? $urandom
           : (pick < 6) ? delay : $urandom_range(0, int'(span)));
        pick = $urandom_range(0, 99);
        if (!seq_loop_en && seq_loops != 0 && pick < 30)
          send_request(CMD_RESTART, ELAPSED_W'($urandom), IDX_BITS'($urandom),
                       ID_BITS'($urandom));
        else if (pick < 75)
          send_request(CMD_TICK, ms, IDX_BITS'($urandom), ID_BITS'($urandom));
        else if (pick < 87)
          send_request(CMD_LOAD, ELAPSED_W'($urandom), IDX_BITS'($urandom),
                       ID_BITS'($urandom));
        else if (pick < 93)
          send_request(CMD_RESTART, ELAPSED_W'($urandom), IDX_BITS'($urandom),
                       ID_BITS'($urandom));
        else
          send_request(CMD_NOP, ELAPSED_W'($urandom), IDX_BITS'($urandom),
                       ID_BITS'($urandom));
      end
    end
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    cmd         = '0;
    elapsed_ms  = '0;
    entry_index = '0;
    entry_frame = '0;
    out_stall   = 1'b0;
    stall_left  = 0;
    idle_on     = 1'b1;
    mismatches  = 0;
    seq_delay   = '0;
    seq_count   = 7'd1;
    seq_loop_en = 1'b0;
    seq_acc     = '0;
    seq_pos     = '0;
    seq_loops   = '0;
    seq_changed = 1'b0;
    seq_looped  = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_fill_table();
    test_tick_timing();
    test_end_of_animation();
    test_zero_delay();
    test_shrunk_count();
    test_saturation();
    test_random_traffic();

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
